### hw/rtl/stepper_axis_homing_tracker_unit_macros.svh
// assertion macros for the stepper axis homing tracker
`ifndef STEPPER_AXIS_HOMING_TRACKER_UNIT_MACROS_SVH
`define STEPPER_AXIS_HOMING_TRACKER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk and disabled in reset
`define SAHT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and disabled in reset
`define SAHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/saht_pkg.sv
// shared types and constants of the stepper axis homing tracker
package saht_pkg;

  // width and reset value of the full-scale register
  localparam int unsigned FS_BITS = 13;
  localparam logic [FS_BITS-1:0] FS_RESET = 13'd5003;

  // axis operating modes, codes as seen on the result channel
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_HOME_MIN = 2'd1,
    MODE_HOME_MAX = 2'd2,
    MODE_TRACK    = 2'd3
  } mode_t;

  // request kinds
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // half-step coil drive, bit0 coil a through bit3 coil d
  localparam logic [3:0] COIL_TABLE [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  // divider status towards the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hw/rtl/saht_in_if.sv
// request channel of the stepper axis homing tracker
interface saht_in_if #(
  parameter int MV_BITS = 13
) ();
  logic               valid;
  logic               ready;
  logic               action;
  logic               enable_n;
  logic               min_limit_n;
  logic               max_limit_n;
  logic [MV_BITS-1:0] pot_mv;

  modport source (
    output valid, action, enable_n, min_limit_n, max_limit_n, pot_mv,
    input  ready
  );
  modport sink (
    input  valid, action, enable_n, min_limit_n, max_limit_n, pot_mv,
    output ready
  );
endinterface

### hw/rtl/saht_out_if.sv
// result channel of the stepper axis homing tracker
interface saht_out_if #(
  parameter int POSITION_BITS = 16
) ();
  logic                            valid;
  logic                            ready;
  logic [3:0]                      coil_pattern;
  logic                            stepped;
  logic signed [POSITION_BITS-1:0] position;
  logic signed [POSITION_BITS-1:0] goal;
  logic [1:0]                      mode;
  logic [POSITION_BITS-2:0]        span;

  modport source (
    output valid, coil_pattern, stepped, position, goal, mode, span,
    input  ready
  );
  modport sink (
    input  valid, coil_pattern, stepped, position, goal, mode, span,
    output ready
  );
endinterface

### hw/rtl/stepper_axis_homing_tracker_unit.sv
// top level of one half-step stepper axis with homing and pot tracking
// A tick request or a poll request is taken whenever no earlier result is
// still waiting, and its result appears the cycle after acceptance. The one
// exception is a poll in tracking mode with the run switch on and a non-zero
// full scale: it maps the pot reading through a registered multiplier and a
// bit-serial divider, one quotient bit per cycle, and no request is taken
// until the divider is done. Full scale is written through cfg_we/cfg_data.
`include "stepper_axis_homing_tracker_unit_macros.svh"

module stepper_axis_homing_tracker_unit #(
  parameter int POSITION_BITS = 16,
  parameter int MV_BITS       = 13
) (
  input  logic                          clk,
  input  logic                          rst_n,
  saht_in_if.sink                       in_chan,
  saht_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  logic [saht_pkg::FS_BITS-1:0]  cfg_data
);

  localparam int SPAN_W = POSITION_BITS - 1;
  localparam int PROD_W = MV_BITS + SPAN_W;

  localparam logic signed [POSITION_BITS-1:0] POS_TOP =
    {1'b0, {(POSITION_BITS-1){1'b1}}};
  localparam logic signed [POSITION_BITS-1:0] POS_BOTTOM =
    {1'b1, {(POSITION_BITS-1){1'b0}}};

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DIV  = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  saht_pkg::mode_t                 mode_r, mode_nxt;
  logic signed [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic signed [POSITION_BITS-1:0] target_r, target_nxt;
  logic [2:0]                      phase_r, phase_nxt;
  logic [SPAN_W-1:0]               span_r, span_nxt;
  logic                            stepped_r, stepped_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [saht_pkg::FS_BITS-1:0]    fs_r;

  logic                            in_acc;
  logic                            div_start;
  logic [PROD_W-1:0]               prod;
  logic [PROD_W-1:0]               quot;
  saht_pkg::div_stat_t             div_stat;
  logic signed [POSITION_BITS-1:0] span_less_one;

  // full-scale register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r <= saht_pkg::FS_RESET;
    end else if (cfg_we) begin
      fs_r <= cfg_data;
    end
  end

  // request handshake: take a new request while idle once the result slot drains
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign in_acc        = in_chan.valid && in_chan.ready;

  // pot times span, registered inside the divider
  assign prod          = PROD_W'(in_chan.pot_mv) * PROD_W'(span_r);
  assign span_less_one = $signed({1'b0, span_r}) - POSITION_BITS'(1);

  saht_div #(
    .NUM_W (PROD_W),
    .DEN_W (saht_pkg::FS_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (prod),
    .divisor  (fs_r),
    .quotient (quot),
    .stat     (div_stat)
  );

  // tick, mode machine and sequencer
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    target_nxt    = target_r;
    phase_nxt     = phase_r;
    span_nxt      = span_r;
    stepped_nxt   = stepped_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    div_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          stepped_nxt   = 1'b0;
          if (in_chan.action == saht_pkg::ACT_TICK) begin
            // one step toward the goal, saturating at the extremes
            if (pos_r < target_r && pos_r != POS_TOP) begin
              pos_nxt     = pos_r + POSITION_BITS'(1);
              phase_nxt   = phase_r + 3'd1;
              stepped_nxt = 1'b1;
            end else if (pos_r > target_r && pos_r != POS_BOTTOM) begin
              pos_nxt     = pos_r - POSITION_BITS'(1);
              phase_nxt   = phase_r - 3'd1;
              stepped_nxt = 1'b1;
            end
          end else begin
            unique case (mode_r)
              saht_pkg::MODE_IDLE: begin
                if (!in_chan.enable_n) begin
                  target_nxt = POS_BOTTOM;
                  mode_nxt   = saht_pkg::MODE_HOME_MIN;
                end
              end
              saht_pkg::MODE_HOME_MIN: begin
                if (!in_chan.min_limit_n) begin
                  pos_nxt    = '0;
                  target_nxt = POS_TOP;
                  mode_nxt   = saht_pkg::MODE_HOME_MAX;
                end
              end
              saht_pkg::MODE_HOME_MAX: begin
                if (!in_chan.max_limit_n) begin
                  span_nxt   = pos_r[POSITION_BITS-1] ? '0 : pos_r[SPAN_W-1:0];
                  target_nxt = pos_r[POSITION_BITS-1] ? -POSITION_BITS'(1)
                                                      : pos_r - POSITION_BITS'(1);
                  mode_nxt   = saht_pkg::MODE_TRACK;
                end
              end
              saht_pkg::MODE_TRACK: begin
                if (in_chan.enable_n) begin
                  target_nxt = '0;
                  mode_nxt   = saht_pkg::MODE_IDLE;
                end else if (fs_r == '0) begin
                  target_nxt = span_less_one;
                end else begin
                  div_start     = 1'b1;
                  out_valid_nxt = 1'b0;
                  state_nxt     = ST_DIV;
                end
              end
              default: begin
                mode_nxt = saht_pkg::MODE_IDLE;
              end
            endcase
          end
        end
      end
      ST_DIV: begin
        // quotient above span clamps to span minus one
        if (div_stat.done) begin
          if (quot > PROD_W'(span_r)) begin
            target_nxt = span_less_one;
          end else begin
            target_nxt = $signed(quot[POSITION_BITS-1:0]);
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= saht_pkg::MODE_IDLE;
      pos_r       <= '0;
      target_r    <= '0;
      phase_r     <= '0;
      span_r      <= '0;
      stepped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      pos_r       <= pos_nxt;
      target_r    <= target_nxt;
      phase_r     <= phase_nxt;
      span_r      <= span_nxt;
      stepped_r   <= stepped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result channel, state holds while a result waits
  assign out_chan.valid        = out_valid_r;
  assign out_chan.coil_pattern = saht_pkg::COIL_TABLE[phase_r];
  assign out_chan.stepped      = stepped_r;
  assign out_chan.position     = pos_r;
  assign out_chan.goal         = target_r;
  assign out_chan.mode         = mode_r;
  assign out_chan.span         = span_r;

  // checks
  `SAHT_ASSERT_NOW(a_no_accept_in_div, state_r == ST_DIV, !in_chan.ready, "request taken while dividing")
  `SAHT_ASSERT_NEXT(a_div_gives_result, state_r == ST_DIV && div_stat.done, out_valid_r && state_r == ST_IDLE, "division result not presented")
  `SAHT_ASSERT_NOW(a_div_busy_in_div, state_r == ST_DIV && !div_stat.done, div_stat.busy, "divider idle while sequencer waits")
  `SAHT_ASSERT_NOW(a_track_goal_in_span, mode_r == saht_pkg::MODE_TRACK && state_r == ST_IDLE, target_r <= $signed({1'b0, span_r}), "tracking goal beyond span")

endmodule

### hw/rtl/saht_div.sv
// iterative restoring divider, one quotient bit per cycle
module saht_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    dividend,
  input  logic [DEN_W-1:0]    divisor,
  output logic [NUM_W-1:0]    quotient,
  output saht_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;

  // one trial subtraction
  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = (shifted >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient shifts in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], fits};
      rem_r <= fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

  assign quotient  = num_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### tb/sv/stepper_axis_homing_tracker_unit_test.sv
// self-checking testbench for the stepper axis homing tracker top level
module stepper_axis_homing_tracker_unit_test;
  import saht_pkg::*;

  localparam int POS_W          = 16;
  localparam int MV_W           = 13;
  localparam int RANDOM_COUNT   = 1500;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SWEEP_DOWN     = 40;
  localparam int SWEEP_UP       = 60;

  localparam logic signed [POS_W-1:0] POS_TOP    = 16'sh7FFF;
  localparam logic signed [POS_W-1:0] POS_BOTTOM = 16'sh8000;
  localparam logic [MV_W-1:0]         MV_MAX     = 13'h1FFF;

  // half-step coil drive per phase, bit0 coil a
  localparam logic [3:0] HALF_STEP_COILS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic            action;
    logic            enable_n;
    logic            min_limit_n;
    logic            max_limit_n;
    logic [MV_W-1:0] pot_mv;
  } axis_request_t;

  localparam int REQ_W = $bits(axis_request_t);

  typedef struct packed {
    logic [3:0]              coil;
    logic                    stepped;
    logic signed [POS_W-1:0] position;
    logic signed [POS_W-1:0] goal;
    mode_t                   mode;
    logic [POS_W-2:0]        span;
  } axis_result_t;

  // predicts each result of the axis and matches it against the block
  class axis_result_board;
    mode_t                   cur_mode;
    logic signed [POS_W-1:0] cur_pos;
    logic signed [POS_W-1:0] cur_goal;
    logic [2:0]              coil_phase;
    logic [POS_W-1:0]        travel_span;
    logic [FS_BITS-1:0]      full_scale_mv;
    axis_result_t            pending_results[$];
    int                      errors;
    int                      n_checked;
    int                      n_homings;
    int                      n_track_polls;

    function new();
      cur_mode      = MODE_IDLE;
      cur_pos       = '0;
      cur_goal      = '0;
      coil_phase    = '0;
      travel_span   = '0;
      full_scale_mv = FS_RESET;
      errors        = 0;
      n_checked     = 0;
      n_homings     = 0;
      n_track_polls = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // work out the result of one accepted request
    function void note_request(axis_request_t r);
      axis_result_t    e;
      longint unsigned q;
      e.stepped = 1'b0;
      if (r.action == ACT_TICK) begin
        if (cur_pos < cur_goal && cur_pos != POS_TOP) begin
          coil_phase = coil_phase + 3'd1;
          cur_pos    = cur_pos + 16'sd1;
          e.stepped  = 1'b1;
        end else if (cur_pos > cur_goal && cur_pos != POS_BOTTOM) begin
          coil_phase = coil_phase - 3'd1;
          cur_pos    = cur_pos - 16'sd1;
          e.stepped  = 1'b1;
        end
      end else begin
        case (cur_mode)
          MODE_IDLE: begin
            if (!r.enable_n) begin
              cur_goal = POS_BOTTOM;
              cur_mode = MODE_HOME_MIN;
            end
          end
          MODE_HOME_MIN: begin
            if (!r.min_limit_n) begin
              cur_pos  = '0;
              cur_goal = POS_TOP;
              cur_mode = MODE_HOME_MAX;
            end
          end
          MODE_HOME_MAX: begin
            if (!r.max_limit_n) begin
              travel_span = cur_pos[POS_W-1] ? '0 : cur_pos;
              cur_goal    = $signed(travel_span - 16'd1);
              cur_mode    = MODE_TRACK;
              n_homings++;
            end
          end
          default: begin
            if (!r.enable_n) begin
              n_track_polls++;
              if (full_scale_mv == '0) begin
                cur_goal = $signed(travel_span - 16'd1);
              end else begin
                q = (longint'(r.pot_mv) * longint'(travel_span)) / longint'(full_scale_mv);
                cur_goal = (q > travel_span) ? $signed(travel_span - 16'd1)
                                             : $signed(q[POS_W-1:0]);
              end
            end else begin
              cur_goal = '0;
              cur_mode = MODE_IDLE;
            end
          end
        endcase
      end
      e.coil     = HALF_STEP_COILS[coil_phase];
      e.position = cur_pos;
      e.goal     = cur_goal;
      e.mode     = cur_mode;
      e.span     = travel_span[POS_W-2:0];
      pending_results.push_back(e);
    endfunction

    function void report(string what, longint want, longint got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(axis_result_t got);
      axis_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with no request waiting, actual position %0d",
                 $time, got.position);
        return;
      end
      want = pending_results.pop_front();
      n_checked++;
      if (got.coil !== want.coil)         report("coil_pattern", want.coil, got.coil);
      if (got.stepped !== want.stepped)   report("stepped", want.stepped, got.stepped);
      if (got.position !== want.position) report("position", want.position, got.position);
      if (got.goal !== want.goal)         report("goal", want.goal, got.goal);
      if (got.mode !== want.mode)         report("mode", want.mode, got.mode);
      if (got.span !== want.span)         report("span", want.span, got.span);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [FS_BITS-1:0] cfg_data;

  saht_in_if  #(.MV_BITS(MV_W))        in_chan ();
  saht_out_if #(.POSITION_BITS(POS_W)) out_chan ();

  stepper_axis_homing_tracker_unit #(
    .POSITION_BITS(POS_W),
    .MV_BITS      (MV_W)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  axis_result_board board = new();
  bit calm;
  bit hold_pending;
  int n_requests;
  int n_cfg_writes;
  int quiet_cycles;

  // clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random back-pressure plus one long hold-off on demand
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
      end else begin
        out_chan.ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready)
      board.check_result('{out_chan.coil_pattern, out_chan.stepped, out_chan.position,
                           out_chan.goal, mode_t'(out_chan.mode), out_chan.span});
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, board.pending());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic axis_request_t rand_tick();
    return '{ACT_TICK, 1'($urandom), 1'($urandom), 1'($urandom), MV_W'($urandom)};
  endfunction

  function automatic axis_request_t rand_poll(logic en_n, logic min_n, logic max_n);
    return '{ACT_POLL, en_n, min_n, max_n, MV_W'($urandom)};
  endfunction

  function automatic axis_request_t pot_poll(logic [MV_W-1:0] pot);
    return '{ACT_POLL, 1'b0, 1'($urandom), 1'($urandom), pot};
  endfunction

  // offer one request after a random gap and wait for it to be taken
  task automatic send_req(input axis_request_t r);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.action      <= r.action;
    in_chan.enable_n    <= r.enable_n;
    in_chan.min_limit_n <= r.min_limit_n;
    in_chan.max_limit_n <= r.max_limit_n;
    in_chan.pot_mv      <= r.pot_mv;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    board.note_request(r);
    n_requests++;
  endtask

  // stop offering and wait for every predicted result
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [FS_BITS-1:0] value);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.full_scale_mv = value;
    n_cfg_writes++;
  endtask

  // stimulus
  initial begin
    axis_request_t r;
    mode_t         last_mode;
    int            roll;
    int            max_hit_pm;
    logic [FS_BITS-1:0] fs_pick;

    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_data            <= '0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= ACT_TICK;
    in_chan.enable_n    <= 1'b1;
    in_chan.min_limit_n <= 1'b1;
    in_chan.max_limit_n <= 1'b1;
    in_chan.pot_mv      <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, idle poll with run switch off and limits pressed
    send_req('{ACT_TICK, 1'b1, 1'b1, 1'b1, MV_MAX});
    send_req('{ACT_POLL, 1'b1, 1'b0, 1'b0, MV_MAX});
    // start homing with min already pressed, then run switch off during homing
    send_req('{ACT_POLL, 1'b0, 1'b0, 1'b1, '0});
    send_req('{ACT_POLL, 1'b1, 1'b1, 1'b0, '0});
    repeat (3) send_req(rand_tick());
    // one mode step per poll, then zero span
    send_req('{ACT_POLL, 1'b0, 1'b0, 1'b0, '0});
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b0, '0});
    send_req(rand_tick());
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b1, MV_MAX});
    send_req(rand_tick());
    send_req('{ACT_POLL, 1'b1, 1'b1, 1'b1, '0});
    // short span, limits crossed over, clamp of the mapped goal
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b1, '0});
    send_req('{ACT_POLL, 1'b0, 1'b0, 1'b1, '0});
    repeat (5) send_req(rand_tick());
    send_req('{ACT_POLL, 1'b1, 1'b0, 1'b0, '0});
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b1, MV_MAX});
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b1, 13'd5003});
    send_req('{ACT_POLL, 1'b0, 1'b1, 1'b1, '0});
    send_req(rand_tick());
    send_req('{ACT_POLL, 1'b1, 1'b1, 1'b1, '0});

    // sweep: home over a moderate travel and map the pot across it
    write_full_scale(MV_MAX);
    send_req(rand_poll(1'b0, 1'b1, 1'($urandom)));
    repeat (SWEEP_DOWN) send_req(rand_tick());
    send_req(rand_poll(1'($urandom), 1'b0, 1'($urandom)));
    repeat (SWEEP_UP) send_req(rand_tick());
    send_req(rand_poll(1'($urandom), 1'($urandom), 1'b0));
    send_req(pot_poll(MV_MAX));
    send_req(pot_poll('0));
    repeat (4) send_req(rand_tick());
    write_full_scale(13'd1);
    send_req(pot_poll(13'd1));
    send_req(pot_poll(13'd2));
    send_req(pot_poll(MV_MAX));
    send_req(rand_tick());
    send_req(rand_poll(1'b1, 1'($urandom), 1'($urandom)));

    // random part, mostly well-formed homing and tracking runs
    write_full_scale(FS_RESET);
    last_mode  = board.cur_mode;
    max_hit_pm = 30;
    for (int i = 0; i < RANDOM_COUNT; i++) begin
      if (i % 200 == 100) begin
        roll = $urandom_range(5);
        case (roll)
          0:       fs_pick = '0;
          1:       fs_pick = 13'd1;
          2:       fs_pick = MV_MAX;
          default: fs_pick = FS_BITS'($urandom_range(8191, 1));
        endcase
        write_full_scale(fs_pick);
      end
      if (i == 400) hold_pending = 1'b1;
      calm = (i >= 800 && i < 1000);
      if (board.cur_mode == MODE_HOME_MAX && last_mode != MODE_HOME_MAX)
        max_hit_pm = ($urandom_range(9) == 0) ? 3 : 30;
      last_mode = board.cur_mode;

      roll = $urandom_range(99);
      if (roll < 5) begin
        r = axis_request_t'(REQ_W'($urandom));
      end else begin
        case (board.cur_mode)
          MODE_IDLE: begin
            if (roll < 70)      r = rand_poll(1'b0, 1'($urandom), 1'($urandom));
            else if (roll < 85) r = rand_tick();
            else                r = rand_poll(1'b1, 1'($urandom), 1'($urandom));
          end
          MODE_HOME_MIN: begin
            if (roll < 20)      r = rand_poll(1'($urandom), 1'b0, 1'($urandom));
            else if (roll < 60) r = rand_tick();
            else                r = rand_poll(1'($urandom), 1'b1, 1'($urandom));
          end
          MODE_HOME_MAX: begin
            if ($urandom_range(999) < max_hit_pm)
              r = rand_poll(1'($urandom), 1'($urandom), 1'b0);
            else if (roll < 90) r = rand_tick();
            else                r = rand_poll(1'($urandom), 1'($urandom), 1'b1);
          end
          default: begin
            if (roll < 9)
              r = rand_poll(1'b1, 1'($urandom), 1'($urandom));
            else if (roll < 45) begin
              if ($urandom_range(9) == 0)
                r = pot_poll($urandom_range(1) ? MV_MAX : '0);
              else
                r = pot_poll(MV_W'($urandom_range(8191)));
            end else
              r = rand_tick();
          end
        endcase
      end
      send_req(r);
    end

    // wind down
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d requests and %0d checked results, %0d full-scale writes",
             n_requests, board.n_checked, n_cfg_writes);
    $display("%0d homing runs completed, %0d tracking polls mapped through the pot",
             board.n_homings, board.n_track_polls);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results still outstanding",
               board.errors, board.pending());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
